### hw/rtl/esrt_pkg.sv
`default_nettype none
package esrt_pkg;

    localparam int IN_SAMPLE_W = 16;
    localparam int STAT_W      = 32;
    localparam int FRAC_BITS   = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [STAT_W-1:0] STAT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_ZDIV  = 2'd2,
        ST_DROP  = 2'd3
    } status_t;

    // one queued item
    typedef struct packed {
        logic [IN_SAMPLE_W-1:0] sample;
        logic                   has_sample;
        logic                   last;
    } item_t;

endpackage
`default_nettype wire

### hw/rtl/exponentiality_spacing_ratio_test_top.sv
// exponentiality spacing ratio test (spacing f statistic for exponential data)
// input channel: in_valid / in_stall carry one item: sample, has_sample, last.
//   an item with has_sample set adds its sample to the current set, kept
//   sorted in an internal sample memory; samples past MAX_SAMPLES are dropped
//   and flagged. an item with last set closes the set.
// output channel: out_valid / out_stall carry one item per closed set:
//   statistic (unsigned q16.16, saturated) and status (ok, empty set,
//   zero divisor, samples dropped).
// front: a 4-entry queue takes items one per cycle until it is full, also
//   while the back is busy. back: insertion into the sorted memory reads
//   each larger sample already held and moves it up one slot, a read state
//   and a compare state for each, as there is one memory read port.
//   closing a non-empty set runs the weighted spacing pass (read, multiply,
//   add per sample), then the products, then, unless the divisor is zero,
//   the divider at one quotient bit per cycle, then loads the output register.
// reset clears the queue, the sample count and the pending result; memory
//   contents are not cleared and are never read before being written.
// when the receiver stalls, the result holds in the output register; the back
//   waits only when a second result is ready, and the queue keeps filling
//   until full, then in_stall rises.
`default_nettype none
module exponentiality_spacing_ratio_test_top
    import esrt_pkg::*;
#(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [IN_SAMPLE_W-1:0] sample,
    input  wire logic                   has_sample,
    input  wire logic                   last,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [STAT_W-1:0]           statistic,
    output logic [1:0]                  status
);

    // queue between front and back
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    esrt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .has_sample (has_sample),
        .last       (last),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    // sorted store, spacing sums and divider
    esrt_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .statistic (statistic),
        .status    (status)
    );

endmodule
`default_nettype wire

### hw/rtl/esrt_front.sv
`default_nettype none
module esrt_front
    import esrt_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [IN_SAMPLE_W-1:0] sample,
    input  wire logic                   has_sample,
    input  wire logic                   last,
    output logic                        q_valid,
    output item_t                       q_item,
    input  wire logic                   q_pop
);

    item_t             fifo_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push;
    logic              pop;

    assign in_stall = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    // items with neither a sample nor a set end do nothing, drop them here
    assign push     = in_valid && !in_stall && (has_sample || last);
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= '{sample: sample, has_sample: has_sample, last: last};
        end
    end

endmodule
`default_nettype wire

### hw/rtl/esrt_back.sv
`default_nettype none
module esrt_back
    import esrt_pkg::*;
#(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire item_t             q_item,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [STAT_W-1:0]      statistic,
    output logic [1:0]             status
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int SB = SAMPLE_BITS;
    localparam int TW = SB + CW;
    localparam int PW = TW + CW;
    localparam int DW = PW + FRAC_BITS;
    localparam int KW = $clog2(DW + 1);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_INS_RD   = 11'b000_0000_0010,
        S_INS_CMP  = 11'b000_0000_0100,
        S_INS_FIN  = 11'b000_0000_1000,
        S_DISPATCH = 11'b000_0001_0000,
        S_SUM_RD   = 11'b000_0010_0000,
        S_SUM_MUL  = 11'b000_0100_0000,
        S_SUM_ACC  = 11'b000_1000_0000,
        S_MUL      = 11'b001_0000_0000,
        S_DIV      = 11'b010_0000_0000,
        S_OUT      = 11'b100_0000_0000
    } state_t;

    logic [SB-1:0] mem [MAX_SAMPLES];
    logic [SB-1:0] mem_q_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [SB-1:0] mem_wd;
    logic [AW-1:0] rd_addr;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic                last_reg, last_next;
    logic [SB-1:0]       val_reg, val_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [SB-1:0]       prev_reg, prev_next;
    logic [TW-1:0]       w_reg, w_next;
    logic [TW-1:0]       lower_reg, lower_next;
    logic [TW-1:0]       upper_reg, upper_next;
    logic [PW-1:0]       div_b_reg, div_b_next;
    logic [DW-1:0]       dvd_reg, dvd_next;
    logic [PW-1:0]       rem_reg, rem_next;
    logic [STAT_W-1:0]   quo_reg, quo_next;
    logic                sat_reg, sat_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [STAT_W-1:0]   res_stat_reg, res_stat_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]   stat_out_reg, stat_out_next;
    logic [1:0]          status_out_reg, status_out_next;

    logic [IN_SAMPLE_W+31:0] ext;
    logic [SB-1:0]           sample_v;
    logic [CW-1:0]           r_half;
    logic [SB-1:0]           gap;
    logic [TW-1:0]           prod;
    logic [PW-1:0]           a_val;
    logic [PW-1:0]           b_val;
    logic [PW:0]             rem2;
    logic                    ge;

    assign ext       = {32'b0, q_item.sample};
    assign sample_v  = ext[SB-1:0];
    assign r_half    = count_reg >> 1;
    assign gap       = (idx_reg == '0) ? mem_q_reg : mem_q_reg - prev_reg;
    assign prod      = TW'(gap) * TW'(count_reg - idx_reg);
    assign a_val     = PW'(lower_reg) * PW'(count_reg - r_half);
    assign b_val     = PW'(upper_reg) * PW'(r_half);
    assign rem2      = {rem_reg, dvd_reg[DW-1]};
    assign ge        = (rem2 >= {1'b0, div_b_reg});

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign statistic = stat_out_reg;
    assign status    = status_out_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        last_next       = last_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        prev_next       = prev_reg;
        w_next          = w_reg;
        lower_next      = lower_reg;
        upper_next      = upper_reg;
        div_b_next      = div_b_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        sat_next        = sat_reg;
        k_next          = k_reg;
        res_stat_next   = res_stat_reg;
        res_status_next = res_status_reg;
        stat_out_next   = stat_out_reg;
        status_out_next = status_out_reg;
        out_valid_next  = out_valid_reg && out_stall;
        mem_we          = 1'b0;
        mem_wa          = pos_reg;
        mem_wd          = val_reg;
        rd_addr         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    val_next   = sample_v;
                    last_next  = q_item.last;
                    state_next = S_DISPATCH;
                    if (q_item.has_sample)
                    begin
                        if (count_reg < CW'(MAX_SAMPLES))
                        begin
                            if (count_reg == '0)
                            begin
                                mem_we     = 1'b1;
                                mem_wa     = '0;
                                mem_wd     = sample_v;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                pos_next   = count_reg[AW-1:0];
                                state_next = S_INS_RD;
                            end
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
            end
            S_INS_RD:
            begin
                rd_addr    = pos_reg - 1'b1;
                state_next = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                mem_we = 1'b1;
                if (mem_q_reg > val_reg)
                begin
                    // move the larger neighbor up one slot
                    mem_wd     = mem_q_reg;
                    pos_next   = pos_reg - 1'b1;
                    state_next = (pos_reg == AW'(1)) ? S_INS_FIN : S_INS_RD;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_INS_FIN:
            begin
                mem_we     = 1'b1;
                count_next = count_reg + 1'b1;
                state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                if (last_reg)
                begin
                    idx_next   = '0;
                    prev_next  = '0;
                    lower_next = '0;
                    upper_next = '0;
                    state_next = (count_reg == '0) ? S_MUL : S_SUM_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SUM_RD:
            begin
                rd_addr    = idx_reg[AW-1:0];
                state_next = S_SUM_MUL;
            end
            S_SUM_MUL:
            begin
                w_next     = prod;
                prev_next  = mem_q_reg;
                state_next = S_SUM_ACC;
            end
            S_SUM_ACC:
            begin
                if ((idx_reg == '0) || (idx_reg < r_half))
                begin
                    lower_next = lower_reg + w_reg;
                end
                else
                begin
                    upper_next = upper_reg + w_reg;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_reg + 1'b1 == count_reg) ? S_MUL : S_SUM_RD;
            end
            S_MUL:
            begin
                div_b_next = b_val;
                dvd_next   = {a_val, {FRAC_BITS{1'b0}}};
                rem_next   = '0;
                quo_next   = '0;
                sat_next   = 1'b0;
                k_next     = KW'(DW);
                if (count_reg == '0)
                begin
                    res_stat_next   = '0;
                    res_status_next = ST_EMPTY;
                    state_next      = S_OUT;
                end
                else if ((r_half == '0) || (upper_reg == '0))
                begin
                    res_stat_next   = STAT_MAX;
                    res_status_next = ovf_reg ? ST_DROP : ST_ZDIV;
                    state_next      = S_OUT;
                end
                else
                begin
                    res_status_next = ovf_reg ? ST_DROP : ST_OK;
                    state_next      = S_DIV;
                end
            end
            S_DIV:
            begin
                // restoring division, one quotient bit a cycle
                rem_next = ge ? PW'(rem2 - {1'b0, div_b_reg}) : rem2[PW-1:0];
                dvd_next = dvd_reg << 1;
                quo_next = {quo_reg[STAT_W-2:0], ge};
                sat_next = sat_reg || quo_reg[STAT_W-1];
                k_next   = k_reg - 1'b1;
                if (k_reg == KW'(1))
                begin
                    res_stat_next = sat_next ? STAT_MAX : quo_next;
                    state_next    = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    stat_out_next   = res_stat_reg;
                    status_out_next = res_status_reg;
                    count_next      = '0;
                    ovf_next        = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg       <= last_next;
        val_reg        <= val_next;
        pos_reg        <= pos_next;
        idx_reg        <= idx_next;
        prev_reg       <= prev_next;
        w_reg          <= w_next;
        lower_reg      <= lower_next;
        upper_reg      <= upper_next;
        div_b_reg      <= div_b_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        sat_reg        <= sat_next;
        res_stat_reg   <= res_stat_next;
        res_status_reg <= res_status_next;
        stat_out_reg   <= stat_out_next;
        status_out_reg <= status_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        mem_q_reg <= mem[rd_addr];
    end

endmodule
`default_nettype wire

### hw/rtl/esrt_checker.sv
`default_nettype none
module esrt_checker
    import esrt_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [STAT_W-1:0] statistic,
    input wire logic [1:0]        status
);

    // held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(statistic) && $stable(status))
        else $error("stalled result changed");

    // empty set reports zero
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> (statistic == '0))
        else $error("empty set with nonzero statistic");

    // zero divisor saturates
    a_zdiv: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_ZDIV) |-> (statistic == STAT_MAX))
        else $error("zero divisor not saturated");

endmodule

bind exponentiality_spacing_ratio_test_top esrt_checker u_esrt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .statistic (statistic),
    .status    (status)
);
`default_nettype wire

### dv/tb_exponentiality_spacing_ratio_test_top.sv
`timescale 1ns / 1ps
module tb_exponentiality_spacing_ratio_test_top;
    import esrt_pkg::*;

    localparam int CAPACITY = 1024;
    localparam int HOLD_LEN = 400;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [IN_SAMPLE_W-1:0] sample;
    logic                   has_sample;
    logic                   last;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [STAT_W-1:0]      statistic;
    logic [1:0]             status;

    exponentiality_spacing_ratio_test_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .has_sample (has_sample),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .statistic  (statistic),
        .status     (status)
    );

    // expected ratio results, oldest first
    logic [STAT_W-1:0] ratio_expected_q[$];
    status_t           status_expected_q[$];

    // predictor copy of the current set
    logic [15:0] set_samples[$];
    bit          set_dropped;

    int mismatch_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles = 0;    // cycles of forced receiver stall left
    bit hold_req;           // toggled to request a long hold-off
    bit hold_ack = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // q16.16 quotient rounded toward zero, saturated
    function automatic logic [31:0] quotient_q16(longint unsigned a, longint unsigned b);
        longint unsigned whole;
        longint unsigned rem;
        logic [15:0]     frac;
        whole = a / b;
        rem = a % b;
        frac = '0;
        if (whole >= 65536)
            return STAT_MAX;
        for (int k = 0; k < 16; k++)
        begin
            rem = rem << 1;
            frac = frac << 1;
            if (rem >= b)
            begin
                rem = rem - b;
                frac[0] = 1'b1;
            end
        end
        return {whole[15:0], frac};
    endfunction

    // add a sample and, on set close, queue the expected statistic
    task automatic predict_item(logic [15:0] s, bit hs, bit lst);
        longint unsigned n, r, lo, hi, gap;
        logic [31:0]     stat;
        status_t         st;
        if (hs)
        begin
            if (set_samples.size() < CAPACITY)
                set_samples.insert(set_samples.size(), s);
            else
                set_dropped = 1'b1;
        end
        if (!lst)
            return;
        set_samples.sort();
        n = set_samples.size();
        r = n / 2;
        lo = 0;
        hi = 0;
        for (int i = 0; i < n; i++)
        begin
            gap = (i == 0) ? set_samples[0] : set_samples[i] - set_samples[i-1];
            if (i == 0 || i < r)
                lo += gap * (n - i);
            else
                hi += gap * (n - i);
        end
        if (n == 0)
        begin
            stat = '0;
            st = ST_EMPTY;
        end
        else if (r == 0 || hi == 0)
        begin
            stat = STAT_MAX;
            st = ST_ZDIV;
        end
        else
        begin
            stat = quotient_q16(lo * (n - r), hi * r);
            st = ST_OK;
        end
        if (set_dropped && n != 0)
            st = ST_DROP;
        ratio_expected_q.insert(ratio_expected_q.size(), stat);
        status_expected_q.insert(status_expected_q.size(), st);
        set_samples.delete();
        set_dropped = 1'b0;
    endtask

    // offer one item and wait until it is taken
    task automatic send_item(logic [15:0] s, bit hs, bit lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample <= s;
        has_sample <= hs;
        last <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_item(s, hs, lst);
        @(negedge clk);
    endtask

    // stop offering and wait for every expected result
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (ratio_expected_q.size() != 0);
    endtask

    // random data mixing a few value shapes
    function automatic logic [15:0] pick_sample(int shape);
        case (shape)
            0: return 16'($urandom_range(65535));
            1: return 16'($urandom_range(15));
            2: return 16'hFFFF - 16'($urandom_range(3));
            default: return 16'($urandom_range(2000));
        endcase
    endfunction

    task automatic send_set(int len, int shape);
        for (int i = 0; i < len; i++)
            send_item(pick_sample(shape), 1'b1, i == len - 1);
        if (len == 0)
            send_item(16'($urandom), 1'b0, 1'b1);
    endtask

    // empty set, single, a pair, extremes, all-zero, ties, bare close
    task automatic test_directed();
        send_item(16'h0000, 1'b0, 1'b1);
        send_item(16'hFFFF, 1'b1, 1'b1);
        send_item(16'h0000, 1'b1, 1'b0);
        send_item(16'hFFFF, 1'b1, 1'b1);
        send_item(16'h0000, 1'b1, 1'b0);
        send_item(16'h0000, 1'b1, 1'b0);
        send_item(16'h0000, 1'b1, 1'b1);
        send_item(16'h5555, 1'b0, 1'b0);    // ignored item
        send_item(16'h0007, 1'b1, 1'b0);
        send_item(16'h0007, 1'b1, 1'b0);
        send_item(16'h0007, 1'b1, 1'b0);
        send_item(16'hAAAA, 1'b0, 1'b1);    // bare close of a tied set
        send_item(16'h0001, 1'b1, 1'b0);
        send_item(16'h0002, 1'b1, 1'b0);
        send_item(16'h0003, 1'b1, 1'b0);
        send_item(16'hFFFF, 1'b1, 1'b1);
        send_item(16'hFFFF, 1'b1, 1'b0);
        send_item(16'h8000, 1'b1, 1'b0);
        send_item(16'h0001, 1'b1, 1'b1);
        wait_drained();
    endtask

    // mostly small sets of random content, a few noise items between
    task automatic test_random_sets(int item_budget);
        int sent;
        int len;
        sent = 0;
        while (sent < item_budget)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(6);
            if ($urandom_range(7) == 0)
                send_item(16'($urandom), 1'b0, 1'b0);
            send_set(len, $urandom_range(3));
            sent += (len == 0) ? 1 : len;
        end
        wait_drained();
    endtask

    // overfill the sample memory once, drops with and without the set end
    task automatic test_overflow();
        for (int i = 0; i < CAPACITY + 3; i++)
            send_item(16'($urandom), 1'b1, i == CAPACITY + 2);
        wait_drained();
    endtask

    // long receiver hold-off while items keep coming in
    task automatic test_backpressure();
        hold_req = ~hold_req;
        for (int i = 0; i < 30; i++)
            send_item(pick_sample(0), 1'b1, 1'b1);
        wait_drained();
    endtask

    // receiver side: random stall and forced hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else if (hold_req != hold_ack)
        begin
            out_stall <= 1'b1;
            hold_ack <= hold_req;
            hold_cycles <= HOLD_LEN - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (ratio_expected_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result statistic %h status %0d", statistic, status);
            end
            else
            begin
                if (statistic !== ratio_expected_q[0] || status !== status_expected_q[0])
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h/%0d actual %h/%0d",
                                 ratio_expected_q[0], status_expected_q[0],
                                 statistic, status);
                end
                void'(ratio_expected_q.pop_front());
                void'(status_expected_q.pop_front());
            end
        end
    end

    // run limit
    initial
    begin
        #100ms;
        $display("tb_exponentiality_spacing_ratio_test_top NOT OK");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample = '0;
        has_sample = 1'b0;
        last = 1'b0;
        mismatch_count = 0;
        hold_req = 1'b0;
        set_dropped = 1'b0;
        send_idle_pct = 28;
        recv_idle_pct = 67;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_sets(90);
        send_idle_pct = 67;
        recv_idle_pct = 28;
        test_random_sets(90);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_sets(90);
        test_overflow();

        // latency margin past the last result
        repeat (200) @(negedge clk);
        if (mismatch_count == 0 && ratio_expected_q.size() == 0)
            $display("tb_exponentiality_spacing_ratio_test_top OK");
        else
            $display("tb_exponentiality_spacing_ratio_test_top NOT OK");
        $finish;
    end

endmodule
